// ----- rtl/midi_arpeggiator_top_defines.svh -----
// Assertion macros used by the arpeggiator datapath.
`ifndef MIDI_ARPEGGIATOR_TOP_DEFINES_SVH
`define MIDI_ARPEGGIATOR_TOP_DEFINES_SVH

`ifndef SYNTH

// cons must hold in the same cycle as ante
`define ARP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpeggiator check failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ARP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpeggiator check failed: next-cycle implication");

`else

`define ARP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ARP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/arp_pkg.sv -----
package arp_pkg;

   localparam int MAX_KEYS  = 128;
   localparam int KEY_W     = 7;
   localparam int IDX_W     = $clog2(MAX_KEYS);
   localparam int CNT_W     = $clog2(MAX_KEYS + 1);
   localparam int STEP_W    = 24;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int TDATA_W   = 8;

   localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_UPWARDS     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_FRAMES = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_INS_SHIFT_RD,
      ST_INS_SHIFT_WR,
      ST_START,
      ST_RM_SHIFT_RD,
      ST_RM_SHIFT_WR,
      ST_TICK,
      ST_EMIT_OFF,
      ST_TICK_RD,
      ST_EMIT_ON,
      ST_REPAIR
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN_RD,
      OP_SCAN_STEP,
      OP_SCAN_MISS,
      OP_SCAN_HIT,
      OP_INS_INIT,
      OP_INS_RD,
      OP_INS_WR,
      OP_INS_PUT,
      OP_START,
      OP_RM_DROP,
      OP_RM_RD,
      OP_RM_WR,
      OP_TICK_EVAL,
      OP_EMIT_OFF,
      OP_TICK_RD,
      OP_EMIT_ON,
      OP_REPAIR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rd_en;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              scan_done;
      logic              scan_stop;
      logic              found;
      logic              full;
      logic              ins_at_pos;
      logic              rm_done;
      logic              tick_due;
      logic              held_empty;
      logic              out_free;
   } dp_status_type;

endpackage

// ----- rtl/arp_ctrl.sv -----
module arp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [arp_pkg::FUNC_W-1:0]   req_func,
   input  arp_pkg::dp_status_type       status,
   output arp_pkg::dp_cmd_type          cmd,
   output logic                         req_tready
);

   arp_pkg::state_type state_ff;
   arp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_func)
                  arp_pkg::FUNC_NOTE_OFF: state_in = arp_pkg::ST_SCAN_RD;
                  arp_pkg::FUNC_NOTE_ON:  state_in = arp_pkg::ST_SCAN_RD;
                  arp_pkg::FUNC_TICK:     state_in = arp_pkg::ST_TICK;
                  default:                state_in = arp_pkg::ST_IDLE;
               endcase
            end
         end
         arp_pkg::ST_SCAN_RD: begin
            state_in = status.scan_done ? arp_pkg::ST_DECIDE : arp_pkg::ST_SCAN_CMP;
         end
         arp_pkg::ST_SCAN_CMP: begin
            state_in = status.scan_stop ? arp_pkg::ST_DECIDE : arp_pkg::ST_SCAN_RD;
         end
         arp_pkg::ST_DECIDE: begin
            case (status.func)
               arp_pkg::FUNC_NOTE_ON: begin
                  state_in = (status.found || status.full) ? arp_pkg::ST_START
                                                           : arp_pkg::ST_INS_SHIFT_RD;
               end
               arp_pkg::FUNC_NOTE_OFF: begin
                  state_in = status.found ? arp_pkg::ST_RM_SHIFT_RD : arp_pkg::ST_REPAIR;
               end
               default: state_in = arp_pkg::ST_REPAIR;
            endcase
         end
         arp_pkg::ST_INS_SHIFT_RD: begin
            state_in = status.ins_at_pos ? arp_pkg::ST_START : arp_pkg::ST_INS_SHIFT_WR;
         end
         arp_pkg::ST_INS_SHIFT_WR: state_in = arp_pkg::ST_INS_SHIFT_RD;
         arp_pkg::ST_START:        state_in = arp_pkg::ST_REPAIR;
         arp_pkg::ST_RM_SHIFT_RD: begin
            state_in = status.rm_done ? arp_pkg::ST_REPAIR : arp_pkg::ST_RM_SHIFT_WR;
         end
         arp_pkg::ST_RM_SHIFT_WR: state_in = arp_pkg::ST_RM_SHIFT_RD;
         arp_pkg::ST_TICK: begin
            state_in = status.tick_due ? arp_pkg::ST_EMIT_OFF : arp_pkg::ST_REPAIR;
         end
         arp_pkg::ST_EMIT_OFF: begin
            if (status.out_free) begin
               state_in = status.held_empty ? arp_pkg::ST_REPAIR : arp_pkg::ST_TICK_RD;
            end
         end
         arp_pkg::ST_TICK_RD: state_in = arp_pkg::ST_EMIT_ON;
         arp_pkg::ST_EMIT_ON: begin
            if (status.out_free) begin
               state_in = arp_pkg::ST_REPAIR;
            end
         end
         arp_pkg::ST_REPAIR: state_in = arp_pkg::ST_IDLE;
         default:            state_in = arp_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.op     = arp_pkg::OP_NONE;
      cmd.rd_en  = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         arp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = arp_pkg::OP_LOAD;
            end
         end
         arp_pkg::ST_SCAN_RD: begin
            if (status.scan_done) begin
               cmd.op = arp_pkg::OP_SCAN_MISS;
            end else begin
               cmd.op    = arp_pkg::OP_SCAN_RD;
               cmd.rd_en = 1'b1;
            end
         end
         arp_pkg::ST_SCAN_CMP: begin
            cmd.op = status.scan_stop ? arp_pkg::OP_SCAN_HIT : arp_pkg::OP_SCAN_STEP;
         end
         arp_pkg::ST_DECIDE: begin
            case (status.func)
               arp_pkg::FUNC_NOTE_ON: begin
                  if (!(status.found || status.full)) begin
                     cmd.op = arp_pkg::OP_INS_INIT;
                  end
               end
               arp_pkg::FUNC_NOTE_OFF: begin
                  if (status.found) begin
                     cmd.op = arp_pkg::OP_RM_DROP;
                  end
               end
               default: cmd.op = arp_pkg::OP_NONE;
            endcase
         end
         arp_pkg::ST_INS_SHIFT_RD: begin
            if (status.ins_at_pos) begin
               cmd.op = arp_pkg::OP_INS_PUT;
            end else begin
               cmd.op    = arp_pkg::OP_INS_RD;
               cmd.rd_en = 1'b1;
            end
         end
         arp_pkg::ST_INS_SHIFT_WR: cmd.op = arp_pkg::OP_INS_WR;
         arp_pkg::ST_START:        cmd.op = arp_pkg::OP_START;
         arp_pkg::ST_RM_SHIFT_RD: begin
            if (!status.rm_done) begin
               cmd.op    = arp_pkg::OP_RM_RD;
               cmd.rd_en = 1'b1;
            end
         end
         arp_pkg::ST_RM_SHIFT_WR: cmd.op = arp_pkg::OP_RM_WR;
         arp_pkg::ST_TICK:        cmd.op = arp_pkg::OP_TICK_EVAL;
         arp_pkg::ST_EMIT_OFF: begin
            if (status.out_free) begin
               cmd.op = arp_pkg::OP_EMIT_OFF;
            end
         end
         arp_pkg::ST_TICK_RD: begin
            cmd.op    = arp_pkg::OP_TICK_RD;
            cmd.rd_en = 1'b1;
         end
         arp_pkg::ST_EMIT_ON: begin
            if (status.out_free) begin
               cmd.op = arp_pkg::OP_EMIT_ON;
            end
         end
         arp_pkg::ST_REPAIR: cmd.op = arp_pkg::OP_REPAIR;
         default:            cmd.op = arp_pkg::OP_NONE;
      endcase
   end

endmodule

// ----- rtl/arp_datapath.sv -----
`include "midi_arpeggiator_top_defines.svh"

module arp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  arp_pkg::dp_cmd_type             cmd,
   output arp_pkg::dp_status_type          status,
   input  logic [arp_pkg::FUNC_W-1:0]      req_func,
   input  logic [arp_pkg::KEY_W-1:0]       req_key,
   input  logic                            csr_we,
   input  logic [arp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arp_pkg::STEP_W-1:0]      csr_wdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_is_note_on,
   output logic [arp_pkg::KEY_W-1:0]       rsp_note_key,
   output logic                            rsp_tlast
);

   localparam int IDX_W = arp_pkg::IDX_W;
   localparam int CNT_W = arp_pkg::CNT_W;
   localparam int KEY_W = arp_pkg::KEY_W;

   // sorted held keys
   logic [KEY_W-1:0] key_mem [arp_pkg::MAX_KEYS];
   logic [KEY_W-1:0] rd_key_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] wr_data;

   logic [arp_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic                       found_ff, found_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           play_ff, play_in;
   logic [KEY_W-1:0]           prev_ff, prev_in;
   logic                       active_ff, active_in;
   logic [arp_pkg::STEP_W-1:0] wait_ff, wait_in;
   logic                       upwards_ff, upwards_in;
   logic [arp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_on_ff, rsp_on_in;
   logic [KEY_W-1:0]           rsp_key_ff, rsp_key_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0] play_ext;
   logic [CNT_W-1:0] play_p1;
   logic [CNT_W-1:0] cnt_p1;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] cnt_m2;
   logic [CNT_W-1:0] idx_p1;
   logic [CNT_W-1:0] idx_m1;
   logic [IDX_W-1:0] play_fix;
   logic             out_free;

   assign play_ext = {1'b0, play_ff};
   assign play_p1  = play_ext + CNT_W'(1);
   assign cnt_p1   = count_ff + CNT_W'(1);
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_m2   = count_ff - CNT_W'(2);
   assign idx_p1   = idx_ff + CNT_W'(1);
   assign idx_m1   = idx_ff - CNT_W'(1);
   assign play_fix = (play_ext >= count_ff) ? '0 : play_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign status.func       = func_ff;
   assign status.scan_done  = idx_ff >= count_ff;
   assign status.scan_stop  = (func_ff == arp_pkg::FUNC_NOTE_ON) ? (rd_key_ff >= key_ff)
                                                                : (rd_key_ff == key_ff);
   assign status.found      = found_ff;
   assign status.full       = count_ff == CNT_W'(arp_pkg::MAX_KEYS);
   assign status.ins_at_pos = idx_ff == pos_ff;
   assign status.rm_done    = idx_ff >= count_ff;
   assign status.tick_due   = active_ff && (step_ff != '0) && (wait_ff == '0);
   assign status.held_empty = count_ff == '0;
   assign status.out_free   = out_free;

   always_comb begin
      logic rsp_load;
      rsp_load    = 1'b0;
      func_in     = func_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      play_in     = play_ff;
      prev_in     = prev_ff;
      active_in   = active_ff;
      wait_in     = wait_ff;
      rsp_on_in   = rsp_on_ff;
      rsp_key_in  = rsp_key_ff;
      rsp_last_in = rsp_last_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = rd_key_ff;
      case (cmd.op)
         arp_pkg::OP_LOAD: begin
            func_in = req_func;
            key_in  = req_key;
            idx_in  = '0;
         end
         arp_pkg::OP_SCAN_RD: rd_addr = idx_ff[IDX_W-1:0];
         arp_pkg::OP_SCAN_STEP: idx_in = idx_p1;
         arp_pkg::OP_SCAN_MISS: begin
            pos_in   = idx_ff;
            found_in = 1'b0;
         end
         arp_pkg::OP_SCAN_HIT: begin
            pos_in   = idx_ff;
            found_in = rd_key_ff == key_ff;
         end
         arp_pkg::OP_INS_INIT: idx_in = count_ff;
         arp_pkg::OP_INS_RD: rd_addr = idx_m1[IDX_W-1:0];
         arp_pkg::OP_INS_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rd_key_ff;
            idx_in  = idx_m1;
         end
         arp_pkg::OP_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IDX_W-1:0];
            wr_data  = key_ff;
            count_in = cnt_p1;
            if (play_ext > pos_ff) begin
               play_in = play_p1[IDX_W-1:0];
            end else if ((pos_ff == count_ff) && (play_ff == '0)) begin
               // appended at the top while the pointer sat at the bottom
               play_in = pos_ff[IDX_W-1:0];
            end
         end
         arp_pkg::OP_START: begin
            if (!active_ff) begin
               active_in = 1'b1;
               if (upwards_ff || (count_ff == '0)) begin
                  play_in = '0;
               end else begin
                  play_in = cnt_m1[IDX_W-1:0];
               end
            end
         end
         arp_pkg::OP_RM_DROP: begin
            count_in = cnt_m1;
            idx_in   = pos_ff;
            if (upwards_ff && (play_ext > pos_ff)) begin
               play_in = play_ff - IDX_W'(1);
            end else if (!upwards_ff && (play_ext == pos_ff)) begin
               if (play_ff != '0) begin
                  play_in = play_ff - IDX_W'(1);
               end else if (cnt_m1 != '0) begin
                  play_in = cnt_m2[IDX_W-1:0];
               end else begin
                  play_in = '0;
               end
            end
         end
         arp_pkg::OP_RM_RD: rd_addr = idx_p1[IDX_W-1:0];
         arp_pkg::OP_RM_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rd_key_ff;
            idx_in  = idx_p1;
         end
         arp_pkg::OP_TICK_EVAL: begin
            if (active_ff) begin
               if (step_ff == '0) begin
                  wait_in = '0;
               end else if (wait_ff != '0) begin
                  wait_in = wait_ff - arp_pkg::STEP_W'(1);
               end
            end
         end
         arp_pkg::OP_EMIT_OFF: begin
            rsp_load    = 1'b1;
            rsp_on_in   = 1'b0;
            rsp_key_in  = prev_ff;
            rsp_last_in = count_ff == '0;
            if (count_ff == '0) begin
               active_in = 1'b0;
               wait_in   = '0;
            end
         end
         arp_pkg::OP_TICK_RD: begin
            play_in = play_fix;
            rd_addr = play_fix;
         end
         arp_pkg::OP_EMIT_ON: begin
            rsp_load    = 1'b1;
            rsp_on_in   = 1'b1;
            rsp_key_in  = rd_key_ff;
            rsp_last_in = 1'b1;
            prev_in     = rd_key_ff;
            wait_in     = step_ff - arp_pkg::STEP_W'(1);
            if (upwards_ff) begin
               play_in = (play_p1 == count_ff) ? '0 : play_p1[IDX_W-1:0];
            end else begin
               play_in = (play_ff == '0) ? cnt_m1[IDX_W-1:0] : play_ff - IDX_W'(1);
            end
         end
         arp_pkg::OP_REPAIR: begin
            if ((count_ff == '0) || (play_ext >= count_ff)) begin
               play_in = '0;
            end
         end
         default: rsp_load = 1'b0;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      upwards_in = upwards_ff;
      step_in    = step_ff;
      if (csr_we) begin
         case (csr_index)
            arp_pkg::CSR_UPWARDS:     upwards_in = csr_wdata[0];
            arp_pkg::CSR_STEP_FRAMES: step_in    = csr_wdata;
            default:                  step_in    = step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         play_ff      <= '0;
         prev_ff      <= '0;
         active_ff    <= 1'b0;
         wait_ff      <= '0;
         upwards_ff   <= 1'b1;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         play_ff      <= play_in;
         prev_ff      <= prev_in;
         active_ff    <= active_in;
         wait_ff      <= wait_in;
         upwards_ff   <= upwards_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_is_note_on = rsp_on_ff;
   assign rsp_note_key   = rsp_key_ff;
   assign rsp_tlast      = rsp_last_ff;

   logic emit_op;
   logic play_ok;
   assign emit_op = (cmd.op == arp_pkg::OP_EMIT_OFF) || (cmd.op == arp_pkg::OP_EMIT_ON);
   assign play_ok = (count_ff == '0) ? (play_ff == '0) : (play_ext < count_ff);

   `ARP_ASSERT_IMPLY(a_no_overwrite, clock, reset, emit_op, out_free)
   `ARP_ASSERT_NEXT(a_repair_in_range, clock, reset, cmd.op == arp_pkg::OP_REPAIR, play_ok)
   `ARP_ASSERT_NEXT(a_put_grows, clock, reset, cmd.op == arp_pkg::OP_INS_PUT, count_ff == $past(cnt_p1))
   `ARP_ASSERT_NEXT(a_emit_shows, clock, reset, emit_op, rsp_valid_ff)

endmodule

// ----- rtl/midi_arpeggiator_top.sv -----
// Channel  Direction  Fields (low bit up)
// req      in         tuser[1:0] func; tdata[6:0] key
// rsp      out        tuser[0] is_note_on; tdata[6:0] note_key; tlast last
// csr      in         index 0 upwards, index 1 step_frames; wdata[23:0]
//
// One item at a time. A note-on or note-off scans the sorted key memory with
// a read and a compare state per entry, then shifts entries with a read and
// a write state each. A tick counts the step wait down and, when due, emits
// a note-off and, if keys are held, a note-on; each result waits for the
// output register to drain. Reset is synchronous and leaves the key memory
// unwritten; the result register frees the input side while rsp stalls.
module midi_arpeggiator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [arp_pkg::TDATA_W-1:0]     req_tdata,  // [6:0] key
   input  logic [arp_pkg::FUNC_W-1:0]      req_tuser,  // [1:0] func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [arp_pkg::TDATA_W-1:0]     rsp_tdata,  // [6:0] note_key
   output logic                            rsp_tuser,  // [0] is_note_on
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [arp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arp_pkg::STEP_W-1:0]      csr_wdata
);

   arp_pkg::dp_cmd_type            cmd;
   arp_pkg::dp_status_type         status;
   logic [arp_pkg::KEY_W-1:0]      note_key;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {{(arp_pkg::TDATA_W - arp_pkg::KEY_W){1'b0}}, note_key};

   arp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   arp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_tuser),
      .req_key        (req_tdata[arp_pkg::KEY_W-1:0]),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_is_note_on (rsp_tuser),
      .rsp_note_key   (note_key),
      .rsp_tlast      (rsp_tlast)
   );

endmodule
